// ===== rtl/tsd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tsd_pkg;

  localparam int unsigned TypeBits  = 5;
  localparam int unsigned CodeBits  = 10;
  localparam int unsigned ValueBits = 12;
  localparam int unsigned CoordBits = 12;

  localparam logic [TypeBits-1:0] EvSyn = 5'd0;
  localparam logic [TypeBits-1:0] EvKey = 5'd1;
  localparam logic [TypeBits-1:0] EvAbs = 5'd3;

  localparam logic [CodeBits-1:0] AbsX      = 10'd0;
  localparam logic [CodeBits-1:0] AbsY      = 10'd1;
  localparam logic [CodeBits-1:0] SynReport = 10'd0;
  localparam logic [CodeBits-1:0] BtnTouch  = 10'd330;

  typedef enum logic [1:0] {
    DIR_LEFT  = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_UP    = 2'd2,
    DIR_DOWN  = 2'd3
  } dir_e;

  typedef logic [CoordBits-1:0] coord_t;

  typedef struct packed {
    logic vld;
    dir_e dir;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/tsd_track.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tsd_track (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          accept_i,
  input  wire logic [tsd_pkg::TypeBits-1:0]  event_type_i,
  input  wire logic [tsd_pkg::CodeBits-1:0]  event_code_i,
  input  wire logic [tsd_pkg::ValueBits-1:0] event_value_i,
  output tsd_pkg::res_t                      res_o
);

  tsd_pkg::coord_t first_x_q, first_y_q, latest_x_q, latest_y_q;
  tsd_pkg::coord_t start_x_q, start_y_q, end_x_q, end_y_q;
  logic            seen_x_q, seen_y_q;

  tsd_pkg::coord_t v;
  tsd_pkg::coord_t dx, dy;
  logic            is_x, is_y, is_syn, is_rel;

  assign v      = event_value_i[tsd_pkg::CoordBits-1:0];
  assign is_x   = accept_i && (event_type_i == tsd_pkg::EvAbs) && (event_code_i == tsd_pkg::AbsX);
  assign is_y   = accept_i && (event_type_i == tsd_pkg::EvAbs) && (event_code_i == tsd_pkg::AbsY);
  assign is_syn = accept_i && (event_type_i == tsd_pkg::EvSyn)
                  && (event_code_i == tsd_pkg::SynReport);
  assign is_rel = accept_i && (event_type_i == tsd_pkg::EvKey)
                  && (event_code_i == tsd_pkg::BtnTouch) && (event_value_i == '0);

  assign dx = (start_x_q > end_x_q) ? start_x_q - end_x_q : end_x_q - start_x_q;
  assign dy = (start_y_q > end_y_q) ? start_y_q - end_y_q : end_y_q - start_y_q;

  always_comb begin
    res_o.vld = is_rel;
    if (dx > dy) begin
      res_o.dir = (start_x_q > end_x_q) ? tsd_pkg::DIR_LEFT : tsd_pkg::DIR_RIGHT;
    end else begin
      res_o.dir = (start_y_q > end_y_q) ? tsd_pkg::DIR_UP : tsd_pkg::DIR_DOWN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_x_q  <= '0;
      first_y_q  <= '0;
      latest_x_q <= '0;
      latest_y_q <= '0;
      start_x_q  <= '0;
      start_y_q  <= '0;
      end_x_q    <= '0;
      end_y_q    <= '0;
      seen_x_q   <= 1'b0;
      seen_y_q   <= 1'b0;
    end else if (is_rel) begin
      first_x_q  <= '0;
      first_y_q  <= '0;
      latest_x_q <= '0;
      latest_y_q <= '0;
      start_x_q  <= '0;
      start_y_q  <= '0;
      end_x_q    <= '0;
      end_y_q    <= '0;
      seen_x_q   <= 1'b0;
      seen_y_q   <= 1'b0;
    end else if (is_x) begin
      if (!seen_x_q) begin
        first_x_q <= v;
      end
      seen_x_q   <= 1'b1;
      latest_x_q <= v;
    end else if (is_y) begin
      if (!seen_y_q) begin
        first_y_q <= v;
      end
      seen_y_q   <= 1'b1;
      latest_y_q <= v;
    end else if (is_syn && seen_x_q && seen_y_q) begin
      start_x_q <= first_x_q;
      start_y_q <= first_y_q;
      end_x_q   <= latest_x_q;
      end_y_q   <= latest_y_q;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tsd_outbuf.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tsd_outbuf (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire tsd_pkg::res_t res_i,
  output logic         full_o,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output logic [1:0]   direction_o
);

  logic [1:0]    cnt_q, cnt_d;
  tsd_pkg::dir_e dir0_q, dir1_q;
  logic          push, pop;

  assign push        = res_i.vld;
  assign pop         = out_valid_o && !out_stall_i;
  assign out_valid_o = (cnt_q != 2'd0);
  assign full_o      = (cnt_q == 2'd2);
  assign direction_o = dir0_q;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (push && cnt_q == 2'd1) begin
        dir0_q <= res_i.dir;
      end else begin
        dir0_q <= dir1_q;
      end
      if (push && cnt_q == 2'd2) begin
        dir1_q <= res_i.dir;
      end
    end else if (push) begin
      if (cnt_q == 2'd0) begin
        dir0_q <= res_i.dir;
      end else begin
        dir1_q <= res_i.dir;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/touch_swipe_direction_top.sv =====
// A touch release word pushes its direction into the result buffer, from which the output presents it.
// One event word per cycle while the input is not stalled; tracking state updates in the accepting cycle.
// A two-entry result buffer keeps input flowing while one direction waits downstream.
// Input stalls only while both result entries are occupied.
// Reset (rst_ni low, asynchronous) clears all tracked points, seen flags and the buffer.
`timescale 1ns / 1ps
`default_nettype none

module touch_swipe_direction_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [tsd_pkg::TypeBits-1:0]  event_type_i,
  input  wire logic [tsd_pkg::CodeBits-1:0]  event_code_i,
  input  wire logic [tsd_pkg::ValueBits-1:0] event_value_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [1:0]                         direction_o
);

  tsd_pkg::res_t res;
  logic          full;
  logic          accept;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  tsd_track u_track (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .event_type_i  (event_type_i),
    .event_code_i  (event_code_i),
    .event_value_i (event_value_i),
    .res_o         (res)
  );

  tsd_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .direction_o (direction_o)
  );

endmodule

`default_nettype wire

// ===== bench/touch_swipe_direction_top_tb.sv =====
`timescale 1ns / 1ps

module touch_swipe_direction_top_tb;

  localparam int unsigned WordTarget = 1800;
  localparam int unsigned IdleLimit  = 2000;
  localparam int unsigned DrainWait  = 6;

  class swipe_direction_tracker;
    tsd_pkg::coord_t origin_x, origin_y;
    tsd_pkg::coord_t recent_x, recent_y;
    bit              have_x, have_y;
    tsd_pkg::coord_t from_x, from_y;
    tsd_pkg::coord_t to_x, to_y;
    tsd_pkg::dir_e   expected_dirs[$];
    int unsigned     errors;

    function void clear_gesture();
      origin_x = '0;
      origin_y = '0;
      recent_x = '0;
      recent_y = '0;
      have_x   = 1'b0;
      have_y   = 1'b0;
      from_x   = '0;
      from_y   = '0;
      to_x     = '0;
      to_y     = '0;
    endfunction

    function new();
      clear_gesture();
      errors = 0;
    endfunction

    task report(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    function tsd_pkg::dir_e swipe_of_frame();
      tsd_pkg::coord_t span_x, span_y;
      span_x = (from_x > to_x) ? from_x - to_x : to_x - from_x;
      span_y = (from_y > to_y) ? from_y - to_y : to_y - from_y;
      if (span_x > span_y) return (from_x > to_x) ? tsd_pkg::DIR_LEFT : tsd_pkg::DIR_RIGHT;
      return (from_y > to_y) ? tsd_pkg::DIR_UP : tsd_pkg::DIR_DOWN;
    endfunction

    function void note_event(input logic [tsd_pkg::TypeBits-1:0]  ev_type,
                             input logic [tsd_pkg::CodeBits-1:0]  ev_code,
                             input logic [tsd_pkg::ValueBits-1:0] ev_value);
      tsd_pkg::coord_t pos;
      pos = tsd_pkg::coord_t'(ev_value);
      if (ev_type == tsd_pkg::EvAbs && ev_code == tsd_pkg::AbsX) begin
        if (!have_x) begin
          origin_x = pos;
          have_x   = 1'b1;
        end
        recent_x = pos;
      end else if (ev_type == tsd_pkg::EvAbs && ev_code == tsd_pkg::AbsY) begin
        if (!have_y) begin
          origin_y = pos;
          have_y   = 1'b1;
        end
        recent_y = pos;
      end else if (ev_type == tsd_pkg::EvSyn && ev_code == tsd_pkg::SynReport) begin
        if (have_x && have_y) begin
          from_x = origin_x;
          from_y = origin_y;
          to_x   = recent_x;
          to_y   = recent_y;
        end
      end else if (ev_type == tsd_pkg::EvKey && ev_code == tsd_pkg::BtnTouch
                   && ev_value == '0) begin
        expected_dirs.push_back(swipe_of_frame());
        clear_gesture();
      end
    endfunction

    task check_direction(input logic [1:0] got);
      tsd_pkg::dir_e want;
      if (expected_dirs.size() == 0) begin
        report($sformatf("direction %0d with none expected", got));
      end else begin
        want = expected_dirs.pop_front();
        if (got !== want)
          report($sformatf("direction %0d, expected %0d (%s)", got, want, want.name()));
      end
    endtask

    function int unsigned pending();
      return expected_dirs.size();
    endfunction
  endclass

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          in_valid_i = 1'b0;
  logic                          in_stall_o;
  logic [tsd_pkg::TypeBits-1:0]  event_type_i = '0;
  logic [tsd_pkg::CodeBits-1:0]  event_code_i = '0;
  logic [tsd_pkg::ValueBits-1:0] event_value_i = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic [1:0]                    direction_o;

  swipe_direction_tracker tracker = new();
  bit          calm;
  int unsigned words_sent;
  int unsigned idle_cycles;
  int unsigned stall_left;

  touch_swipe_direction_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .event_type_i  (event_type_i),
    .event_code_i  (event_code_i),
    .event_value_i (event_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .direction_o   (direction_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [tsd_pkg::ValueBits-1:0] pick_coord();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 5) return tsd_pkg::ValueBits'($urandom_range(0, 7));
    return tsd_pkg::ValueBits'($urandom);
  endfunction

  task automatic send_word(input logic [tsd_pkg::TypeBits-1:0]  ev_type,
                           input logic [tsd_pkg::CodeBits-1:0]  ev_code,
                           input logic [tsd_pkg::ValueBits-1:0] ev_value);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    event_type_i  = ev_type;
    event_code_i  = ev_code;
    event_value_i = ev_value;
    in_valid_i    = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    words_sent++;
  endtask

  task automatic send_noise();
    int unsigned r;
    r = $urandom_range(0, 3);
    case (r)
      0: send_word(tsd_pkg::EvKey, tsd_pkg::BtnTouch,
                   tsd_pkg::ValueBits'($urandom_range(1, 4095)));
      1: send_word(tsd_pkg::EvAbs, tsd_pkg::CodeBits'($urandom_range(2, 767)),
                   tsd_pkg::ValueBits'($urandom));
      default: send_word(tsd_pkg::TypeBits'($urandom),
                         tsd_pkg::CodeBits'($urandom_range(0, 767)),
                         tsd_pkg::ValueBits'($urandom));
    endcase
  endtask

  task automatic run_directed();
    send_word(tsd_pkg::EvKey, tsd_pkg::BtnTouch, '0);
    send_word(tsd_pkg::EvAbs, tsd_pkg::AbsX, 12'd4095);
    send_word(tsd_pkg::EvAbs, tsd_pkg::AbsX, 12'd0);
    send_word(tsd_pkg::EvAbs, tsd_pkg::AbsY, 12'd2000);
    send_word(tsd_pkg::EvAbs, tsd_pkg::AbsY, 12'd2000);
    send_word(tsd_pkg::EvSyn, tsd_pkg::SynReport, '0);
    send_word(tsd_pkg::EvKey, tsd_pkg::BtnTouch, '0);
    send_word(tsd_pkg::EvAbs, tsd_pkg::AbsX, 12'd0);
    send_word(tsd_pkg::EvAbs, tsd_pkg::AbsY, 12'd4095);
    send_word(tsd_pkg::EvAbs, tsd_pkg::AbsY, 12'd0);
    send_word(tsd_pkg::EvSyn, tsd_pkg::SynReport, '0);
    send_word(tsd_pkg::EvKey, tsd_pkg::BtnTouch, '0);
    send_word(tsd_pkg::EvAbs, tsd_pkg::AbsX, 12'd100);
    send_word(tsd_pkg::EvAbs, tsd_pkg::AbsY, 12'd100);
    send_word(tsd_pkg::EvAbs, tsd_pkg::AbsX, 12'd200);
    send_word(tsd_pkg::EvAbs, tsd_pkg::AbsY, 12'd200);
    send_word(tsd_pkg::EvSyn, tsd_pkg::SynReport, '0);
    send_word(tsd_pkg::EvKey, tsd_pkg::BtnTouch, '0);
    send_word(tsd_pkg::EvAbs, tsd_pkg::AbsX, 12'd5);
    send_word(tsd_pkg::EvSyn, tsd_pkg::SynReport, '0);
    send_word(tsd_pkg::EvKey, tsd_pkg::BtnTouch, 12'd4095);
    send_word(5'd31, 10'd767, 12'd4095);
    send_word(tsd_pkg::EvKey, tsd_pkg::BtnTouch, '0);
  endtask

  task automatic run_gesture();
    int unsigned frames;
    frames = $urandom_range(1, 5);
    if ($urandom_range(0, 9) == 0) send_word(tsd_pkg::EvKey, tsd_pkg::BtnTouch, 12'd1);
    repeat (frames) begin
      if ($urandom_range(0, 9) != 0) send_word(tsd_pkg::EvAbs, tsd_pkg::AbsX, pick_coord());
      if ($urandom_range(0, 9) != 0) send_word(tsd_pkg::EvAbs, tsd_pkg::AbsY, pick_coord());
      if ($urandom_range(0, 7) == 0) send_noise();
      if ($urandom_range(0, 9) != 0) send_word(tsd_pkg::EvSyn, tsd_pkg::SynReport, '0);
    end
    send_word(tsd_pkg::EvKey, tsd_pkg::BtnTouch, '0);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) tracker.check_direction(direction_o);
      if (in_valid_i && !in_stall_o) tracker.note_event(event_type_i, event_code_i, event_value_i);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left != 0) begin
        stall_left--;
        out_stall_i = 1'b1;
      end else begin
        out_stall_i = 1'b0;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  initial begin
    calm        = 1'b0;
    words_sent  = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    run_directed();
    while (words_sent < WordTarget) begin
      if ($urandom_range(0, 7) == 0) calm = ~calm;
      if ($urandom_range(0, 9) == 0)
        send_noise();
      else
        run_gesture();
    end
    in_valid_i = 1'b0;
    calm       = 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (tracker.errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
